[hw/rtl/histogram_binning_counter_defines.svh]
// assertion macros for the histogram binning counter
// used by the checker module; needs nothing else
`ifndef HISTOGRAM_BINNING_COUNTER_DEFINES_SVH
`define HISTOGRAM_BINNING_COUNTER_DEFINES_SVH

// same-cycle implication, held off during reset
`define HBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("histogram_binning_counter: same-cycle check failed");

// next-cycle implication, held off during reset
`define HBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("histogram_binning_counter: next-cycle check failed");

`endif

[hw/rtl/hbc_pkg.sv]
// shared constants, types and control structs of the histogram binning counter
// no dependencies
package hbc_pkg;

   // sizes of the bucket store and the data path
   localparam int MAX_BUCKETS     = 64;
   localparam int COUNT_WIDTH     = 48;
   localparam int SAMPLE_WIDTH    = 32;
   localparam int AMOUNT_WIDTH    = 32;
   localparam int SELECT_WIDTH    = 8;
   localparam int TOTAL_WIDTH     = 7;
   localparam int EXP_WIDTH       = 5;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // derived widths
   localparam int IDX_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NUM_W  = $clog2(MAX_BUCKETS + 1);
   localparam int STEP_W = $clog2(SAMPLE_WIDTH);
   localparam int SUM_W  = ((COUNT_WIDTH > AMOUNT_WIDTH) ? COUNT_WIDTH : AMOUNT_WIDTH) + 1;
   localparam int CMP_A  = (SAMPLE_WIDTH > NUM_W) ? SAMPLE_WIDTH : NUM_W;
   localparam int CMP_B  = (CMP_A > SELECT_WIDTH) ? CMP_A : SELECT_WIDTH;
   localparam int CMP_W  = ((CMP_B > EXP_WIDTH) ? CMP_B : EXP_WIDTH) + 1;

   typedef logic [SAMPLE_WIDTH-1:0]    sample_type;
   typedef logic [AMOUNT_WIDTH-1:0]    amount_type;
   typedef logic [COUNT_WIDTH-1:0]     count_type;
   typedef logic [SELECT_WIDTH-1:0]    select_type;
   typedef logic [TOTAL_WIDTH-1:0]     total_type;
   typedef logic [EXP_WIDTH-1:0]       exp_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic [IDX_W-1:0]           index_type;
   typedef logic [NUM_W-1:0]           num_type;
   typedef logic [CMP_W-1:0]           cmp_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [1:0]                 kind_code_type;

   // item kinds
   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic clear;
      logic step;
      logic pick;
      logic fetch;
      logic update;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      kind_type kind;
      logic     last;
   } stat_type;

endpackage

[hw/rtl/hbc_bin_unit.sv]
// iterative bin unit: restoring divider and leading-one scan, one bit per cycle while step is high
// depends on hbc_pkg
module hbc_bin_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               step,
   input  hbc_pkg::sample_type operand,
   input  hbc_pkg::sample_type divisor,
   output hbc_pkg::sample_type quotient,
   output hbc_pkg::step_type   exponent,
   output logic               found,
   output logic               last
);
   import hbc_pkg::*;

   step_type   cnt_ff;
   logic       found_ff;
   step_type   exp_ff;
   sample_type shift_ff;
   sample_type rem_ff;

   logic [SAMPLE_WIDTH+1:0] trial;
   logic                    borrow;
   logic                    top_bit;
   sample_type              rem_in;

   assign top_bit = shift_ff[SAMPLE_WIDTH-1];

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial  = {1'b0, rem_ff, top_bit} - {2'b00, divisor};
      borrow = trial[SAMPLE_WIDTH+1];
      if (borrow) begin
         rem_in = {rem_ff[SAMPLE_WIDTH-2:0], top_bit};
      end else begin
         rem_in = trial[SAMPLE_WIDTH-1:0];
      end
   end

   // step counter and scan flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (load) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (step) begin
         cnt_ff <= cnt_ff + step_type'(1);
         if (top_bit) begin
            found_ff <= 1'b1;
         end
      end
   end

   // shift register holds the dividend, then the quotient; a zero divisor gives all ones
   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= operand;
         rem_ff   <= '0;
         exp_ff   <= '0;
      end else if (step) begin
         shift_ff <= {shift_ff[SAMPLE_WIDTH-2:0], !borrow};
         rem_ff   <= rem_in;
         if (top_bit && !found_ff) begin
            exp_ff <= step_type'(SAMPLE_WIDTH - 1) - cnt_ff;
         end
      end
   end

   assign quotient = shift_ff;
   assign exponent = exp_ff;
   assign found    = found_ff;
   assign last     = (cnt_ff == step_type'(SAMPLE_WIDTH - 1));

endmodule

[hw/rtl/hbc_datapath.sv]
// datapath: config registers, bucket store, bin selection and saturating update
// depends on hbc_pkg and hbc_bin_unit
module hbc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  hbc_pkg::cmd_type       cmd,
   output hbc_pkg::stat_type      stat,
   input  hbc_pkg::kind_code_type req_kind,
   input  hbc_pkg::sample_type    req_sample_value,
   input  hbc_pkg::amount_type    req_add_amount,
   input  hbc_pkg::select_type    req_bucket_select,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  hbc_pkg::csr_index_type csr_index,
   input  hbc_pkg::csr_data_type  csr_wdata,
   output hbc_pkg::select_type    rsp_bucket_index,
   output hbc_pkg::count_type     rsp_bucket_tally,
   output hbc_pkg::count_type     rsp_total_out
);
   import hbc_pkg::*;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BUCKET_TOTAL = 3'd0,
      CSR_LOG_MODE     = 3'd1,
      CSR_RANGE_MIN    = 3'd2,
      CSR_BUCKET_WIDTH = 3'd3,
      CSR_MIN_EXPONENT = 3'd4
   } csr_reg_type;

   localparam total_type TOTAL_RESET = total_type'(MAX_BUCKETS);

   // clamp the configured bucket count to 1..MAX_BUCKETS
   function automatic num_type buckets_in_use(total_type t);
      cmp_type tw;
      tw = cmp_type'(t);
      if (tw == '0) begin
         return num_type'(1);
      end else if (tw > cmp_type'(MAX_BUCKETS)) begin
         return num_type'(MAX_BUCKETS);
      end
      return num_type'(tw);
   endfunction

   // add that stops at the all-ones count
   function automatic count_type sat_add(count_type a, amount_type b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(b);
      if (s > SUM_W'(count_type'('1))) begin
         return count_type'('1);
      end
      return s[COUNT_WIDTH-1:0];
   endfunction

   // configuration
   total_type  total_cfg_ff;
   logic       log_mode_ff;
   sample_type range_min_ff;
   sample_type width_ff;
   exp_type    min_exp_ff;

   // state
   count_type                total_ff;
   logic [MAX_BUCKETS-1:0]   valid_ff;
   count_type                mem [MAX_BUCKETS];

   // per-item payload
   kind_type   kind_ff;
   amount_type amt_ff;
   logic       above_ff;
   logic       in_range_ff;
   select_type idx_ff;
   count_type  tally_ff;
   count_type  rd_data_ff;
   logic       rd_valid_ff;

   num_type    num_used;
   sample_type bin_operand;
   sample_type quotient;
   step_type   exponent;
   logic       found;
   logic       bin_last;
   logic       zero_bin;
   cmp_type    q_wide;
   index_type  pick_idx;
   index_type  addr;
   count_type  cur_count;
   count_type  new_count;

   assign csr_ready = 1'b1;
   assign num_used  = buckets_in_use(total_cfg_ff);
   assign addr      = idx_ff[IDX_W-1:0];

   // log mode scans the raw sample; linear mode divides the offset from range_min
   assign bin_operand = log_mode_ff ? req_sample_value : (req_sample_value - range_min_ff);

   hbc_bin_unit u_bin (
      .clock    (clock),
      .reset    (reset),
      .load     (cmd.load),
      .step     (cmd.step),
      .operand  (bin_operand),
      .divisor  (width_ff),
      .quotient (quotient),
      .exponent (exponent),
      .found    (found),
      .last     (bin_last)
   );

   // bucket choice with clamping to the first and last bucket
   always_comb begin
      if (log_mode_ff) begin
         zero_bin = !found || (cmp_type'(exponent) <= cmp_type'(min_exp_ff));
         q_wide   = cmp_type'(exponent) - cmp_type'(min_exp_ff);
      end else begin
         zero_bin = !above_ff;
         q_wide   = cmp_type'(quotient);
      end
      if (zero_bin) begin
         pick_idx = '0;
      end else if (q_wide >= cmp_type'(num_used)) begin
         pick_idx = index_type'(num_used - num_type'(1));
      end else begin
         pick_idx = q_wide[IDX_W-1:0];
      end
   end

   // entries never written since reset or clear read as zero
   assign cur_count = rd_valid_ff ? rd_data_ff : '0;
   assign new_count = sat_add(cur_count, amt_ff);

   // config registers, total and entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         total_cfg_ff <= TOTAL_RESET;
         log_mode_ff  <= 1'b0;
         range_min_ff <= '0;
         width_ff     <= sample_type'(1);
         min_exp_ff   <= '0;
         total_ff     <= '0;
         valid_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_reg_type'(csr_index))
               CSR_BUCKET_TOTAL: total_cfg_ff <= csr_wdata[TOTAL_WIDTH-1:0];
               CSR_LOG_MODE:     log_mode_ff  <= csr_wdata[0];
               CSR_RANGE_MIN:    range_min_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
               CSR_BUCKET_WIDTH: width_ff     <= csr_wdata[SAMPLE_WIDTH-1:0];
               CSR_MIN_EXPONENT: min_exp_ff   <= csr_wdata[EXP_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            total_ff <= '0;
            valid_ff <= '0;
         end else if (cmd.update) begin
            total_ff       <= sat_add(total_ff, amt_ff);
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   // bucket store, registered read
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[addr] <= new_count;
      end
      if (cmd.fetch) begin
         rd_data_ff  <= mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= kind_type'(req_kind);
         amt_ff      <= req_add_amount;
         above_ff    <= req_sample_value > range_min_ff;
         in_range_ff <= cmp_type'(req_bucket_select) < cmp_type'(num_used);
         tally_ff    <= '0;
         if (kind_type'(req_kind) == KIND_READ) begin
            idx_ff <= req_bucket_select;
         end else begin
            idx_ff <= '0;
         end
      end else begin
         if (cmd.pick) begin
            idx_ff <= select_type'(pick_idx);
         end
         if (cmd.update) begin
            tally_ff <= new_count;
         end
      end
   end

   assign stat.kind = kind_ff;
   assign stat.last = bin_last;

   // result fields
   assign rsp_bucket_index = idx_ff;
   assign rsp_bucket_tally = (kind_ff == KIND_READ && in_range_ff && rd_valid_ff) ?
                             rd_data_ff : tally_ff;
   assign rsp_total_out    = total_ff;

endmodule

[hw/rtl/hbc_control.sv]
// controller state machine: sequences load, dispatch or clear, divide or scan, pick, fetch, update, result
// depends on hbc_pkg
module hbc_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_strobe,
   output hbc_pkg::cmd_type  cmd,
   input  hbc_pkg::stat_type stat
);
   import hbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ITER,
      ST_PICK,
      ST_FETCH,
      ST_UPDATE,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   // commands decoded from the state
   always_comb begin
      cmd        = '0;
      cmd.load   = start && !busy_ff;
      unique case (state_ff)
         ST_IDLE:     ;
         ST_DISPATCH: cmd.clear  = (stat.kind == KIND_CLEAR);
         ST_ITER:     cmd.step   = 1'b1;
         ST_PICK:     cmd.pick   = 1'b1;
         ST_FETCH:    cmd.fetch  = 1'b1;
         ST_UPDATE:   cmd.update = 1'b1;
         ST_RESP:     ;
      endcase
   end

   // state, busy and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DISPATCH;
                  busy_ff  <= 1'b1;
               end
            end
            ST_DISPATCH: begin
               unique case (stat.kind)
                  KIND_ADD:  state_ff <= ST_ITER;
                  KIND_READ: state_ff <= ST_FETCH;
                  default: begin
                     state_ff  <= ST_RESP;
                     strobe_ff <= 1'b1;
                  end
               endcase
            end
            ST_ITER: begin
               if (stat.last) begin
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: state_ff <= ST_FETCH;
            ST_FETCH: begin
               if (stat.kind == KIND_ADD) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  state_ff  <= ST_RESP;
                  strobe_ff <= 1'b1;
               end
            end
            ST_UPDATE: begin
               state_ff  <= ST_RESP;
               strobe_ff <= 1'b1;
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[hw/rtl/histogram_binning_counter.sv]
// top level of the histogram binning counter
// depends on hbc_pkg, hbc_control, hbc_datapath, hbc_bin_unit
//
// usage:
//   an item is taken at a clock edge with start high and busy low; kind selects add,
//   read or clear (kind 3 only reports the total). every item gives exactly one result,
//   shown on the rsp_ ports for one cycle while rsp_strobe is high; the receiver
//   cannot stall, so it must take the result in that cycle.
//   an add runs the bit-serial divider or leading-one scan, then bin pick, store read
//   and saturating update; a read goes through the store's registered read port; a
//   clear resets the valid bits and the total in the same cycle. busy drops the cycle
//   after the result, so a new item is taken only once the last one is through. the
//   32-step divider sets the add rate.
//   the csr_ port writes one of five registers (bucket_total, log_mode, range_min,
//   bucket_width, min_exponent by index 0..4); csr_ready is always high and writes
//   belong between items.
//   reset clears all bucket counts, the total and the registers to their defaults;
//   there is no clearing pass, the store has a valid bit per entry.
module histogram_binning_counter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hbc_pkg::kind_code_type req_kind,
   input  hbc_pkg::sample_type    req_sample_value,
   input  hbc_pkg::amount_type    req_add_amount,
   input  hbc_pkg::select_type    req_bucket_select,
   output logic                   rsp_strobe,
   output hbc_pkg::select_type    rsp_bucket_index,
   output hbc_pkg::count_type     rsp_bucket_tally,
   output hbc_pkg::count_type     rsp_total_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  hbc_pkg::csr_index_type csr_index,
   input  hbc_pkg::csr_data_type  csr_wdata
);
   import hbc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   hbc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // storage and arithmetic
   hbc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_sample_value  (req_sample_value),
      .req_add_amount    (req_add_amount),
      .req_bucket_select (req_bucket_select),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_bucket_index  (rsp_bucket_index),
      .rsp_bucket_tally  (rsp_bucket_tally),
      .rsp_total_out     (rsp_total_out)
   );

endmodule

[hw/rtl/hbc_checker.sv]
// port-level checks of the histogram binning counter, bound to the top level
// depends on hbc_pkg and histogram_binning_counter_defines.svh
`include "histogram_binning_counter_defines.svh"

module hbc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input hbc_pkg::kind_code_type req_kind,
   input logic                   rsp_strobe,
   input hbc_pkg::count_type     rsp_bucket_tally,
   input hbc_pkg::count_type     rsp_total_out
);
   import hbc_pkg::*;

   logic accept;
   logic clear_accept;
   logic clear_due;
   logic clear_zero;
   logic clear_d1_ff;
   logic clear_d2_ff;

   assign accept       = start && !busy;
   assign clear_accept = accept && (req_kind == KIND_CLEAR);
   assign clear_due    = clear_d2_ff;
   assign clear_zero   = rsp_strobe && rsp_total_out == '0 && rsp_bucket_tally == '0;

   // delay line marking the result cycle of an accepted clear
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_d1_ff <= 1'b0;
         clear_d2_ff <= 1'b0;
      end else begin
         clear_d1_ff <= clear_accept;
         clear_d2_ff <= clear_d1_ff;
      end
   end

   // an accepted item keeps the block busy
   `HBC_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // a result only comes out for an item in flight
   `HBC_ASSERT_IMPLY(a_strobe_busy, clock, reset, rsp_strobe, busy)
   // one result per item, then the block is free again
   `HBC_ASSERT_NEXT(a_strobe_frees, clock, reset, rsp_strobe, !rsp_strobe && !busy)
   // a clear reports a zero tally and zero total in its result cycle
   `HBC_ASSERT_IMPLY(a_clear_result, clock, reset, clear_due, clear_zero)

endmodule

bind histogram_binning_counter hbc_checker u_hbc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_kind         (req_kind),
   .rsp_strobe       (rsp_strobe),
   .rsp_bucket_tally (rsp_bucket_tally),
   .rsp_total_out    (rsp_total_out)
);
